FILE: sv/ray_sphere_intersect_unit_macros.svh
`ifndef RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("rsi assertion failed");

// next-cycle implication
`define RSI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("rsi assertion failed");

`endif

FILE: sv/rsi_pkg.sv
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int COORD_W = 24;
  localparam int FRAC_W  = 12;
  localparam int RAD_W   = 23;
  localparam int OUT_W   = 32;

  localparam int L_W     = COORD_W + 1;
  localparam int PD_W    = L_W + COORD_W;
  localparam int PL_W    = 2 * L_W;
  localparam int R2_W    = 2 * RAD_W;
  localparam int DOT_W   = PD_W + 2;
  localparam int LL_W    = PL_W + 2;
  localparam int TCA_W   = DOT_W - FRAC_W;
  localparam int TL_W    = TCA_W / 2;
  localparam int TH_W    = TCA_W - TL_W;
  localparam int TCA2_W  = 2 * TCA_W;
  localparam int H_W     = TCA2_W + 2;
  localparam int RT_W    = H_W / 2;
  localparam int REM_W   = RT_W + 4;
  localparam int NF_W    = RT_W + 2;

  localparam int FRONT_STAGES = 6;
  localparam int LATENCY      = FRONT_STAGES + RT_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [RAD_W-1:0]   sphere_radius;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] near_t;
    logic signed [OUT_W-1:0] far_t;
  } out_t;

  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [TCA_W-1:0] tca;
  } side_t;

endpackage

FILE: sv/rsi_front.sv
`timescale 1ns / 1ps
module rsi_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  rsi_pkg::in_t            item,
  output rsi_pkg::side_t          side,
  output logic [rsi_pkg::H_W-1:0] h
);

  logic v1, v2, v3, v4, v5, v6;

  logic signed [rsi_pkg::L_W-1:0]     l_x, l_y, l_z;
  logic signed [rsi_pkg::COORD_W-1:0] d_x, d_y, d_z;
  logic        [rsi_pkg::RAD_W-1:0]   r1;

  logic signed [rsi_pkg::PD_W-1:0] pd_x, pd_y, pd_z;
  logic signed [rsi_pkg::PL_W-1:0] pl_x, pl_y, pl_z;
  logic        [rsi_pkg::R2_W-1:0] r2_2;

  logic signed [rsi_pkg::DOT_W-1:0] dot;
  logic        [rsi_pkg::LL_W-1:0]  ll3;
  logic        [rsi_pkg::R2_W-1:0]  r2_3;

  logic                              pos4;
  logic [rsi_pkg::TCA_W-1:0]         tca4;
  logic [2*rsi_pkg::TH_W-1:0]        pp_hh;
  logic [rsi_pkg::TH_W+rsi_pkg::TL_W-1:0] pp_hl;
  logic [2*rsi_pkg::TL_W-1:0]        pp_ll;
  logic [rsi_pkg::LL_W-1:0]          ll4;
  logic [rsi_pkg::R2_W-1:0]          r2_4;

  logic                       pos5;
  logic [rsi_pkg::TCA_W-1:0]  tca5;
  logic [rsi_pkg::TCA2_W-1:0] tca2;
  logic [rsi_pkg::LL_W-1:0]   ll5;
  logic [rsi_pkg::R2_W-1:0]   r2_5;

  logic                       hit6;
  logic [rsi_pkg::TCA_W-1:0]  tca6;

  logic [rsi_pkg::TH_W-1:0] th;
  logic [rsi_pkg::TL_W-1:0] tl;
  logic [rsi_pkg::H_W-1:0]  h_next;

  assign th = dot[rsi_pkg::FRAC_W + rsi_pkg::TL_W +: rsi_pkg::TH_W];
  assign tl = dot[rsi_pkg::FRAC_W +: rsi_pkg::TL_W];
  assign h_next = rsi_pkg::H_W'(r2_5) + rsi_pkg::H_W'(tca2) - rsi_pkg::H_W'(ll5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    l_x <= rsi_pkg::L_W'(item.center_x) - rsi_pkg::L_W'(item.origin_x);
    l_y <= rsi_pkg::L_W'(item.center_y) - rsi_pkg::L_W'(item.origin_y);
    l_z <= rsi_pkg::L_W'(item.center_z) - rsi_pkg::L_W'(item.origin_z);
    d_x <= item.dir_x;
    d_y <= item.dir_y;
    d_z <= item.dir_z;
    r1  <= item.sphere_radius;

    pd_x <= l_x * d_x;
    pd_y <= l_y * d_y;
    pd_z <= l_z * d_z;
    pl_x <= l_x * l_x;
    pl_y <= l_y * l_y;
    pl_z <= l_z * l_z;
    r2_2 <= r1 * r1;

    dot  <= rsi_pkg::DOT_W'(pd_x) + rsi_pkg::DOT_W'(pd_y) + rsi_pkg::DOT_W'(pd_z);
    ll3  <= rsi_pkg::LL_W'($unsigned(pl_x)) + rsi_pkg::LL_W'($unsigned(pl_y))
          + rsi_pkg::LL_W'($unsigned(pl_z));
    r2_3 <= r2_2;

    pos4  <= ~dot[rsi_pkg::DOT_W-1];
    tca4  <= dot[rsi_pkg::FRAC_W +: rsi_pkg::TCA_W];
    pp_hh <= th * th;
    pp_hl <= th * tl;
    pp_ll <= tl * tl;
    ll4   <= ll3;
    r2_4  <= r2_3;

    pos5 <= pos4;
    tca5 <= tca4;
    tca2 <= (rsi_pkg::TCA2_W'(pp_hh) << (2 * rsi_pkg::TL_W))
          + (rsi_pkg::TCA2_W'(pp_hl) << (rsi_pkg::TL_W + 1))
          + rsi_pkg::TCA2_W'(pp_ll);
    ll5  <= ll4;
    r2_5 <= r2_4;

    hit6 <= pos5 & ~h_next[rsi_pkg::H_W-1];
    tca6 <= tca5;
    h    <= h_next;
  end

  assign side = {v6, hit6, tca6};

endmodule

FILE: sv/rsi_sqrt_stage.sv
`timescale 1ns / 1ps
module rsi_sqrt_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  rsi_pkg::side_t            side_i,
  input  logic [rsi_pkg::REM_W-1:0] rem_i,
  input  logic [rsi_pkg::RT_W-1:0]  root_i,
  input  logic [rsi_pkg::H_W-1:0]   h_i,
  output rsi_pkg::side_t            side_o,
  output logic [rsi_pkg::REM_W-1:0] rem_o,
  output logic [rsi_pkg::RT_W-1:0]  root_o,
  output logic [rsi_pkg::H_W-1:0]   h_o
);

  logic [rsi_pkg::REM_W-1:0] remsh;
  logic [rsi_pkg::REM_W-1:0] trial;
  logic                      take;
  logic                      vld;
  logic                      hit;
  logic [rsi_pkg::TCA_W-1:0] tca;

  assign remsh = {rem_i[rsi_pkg::REM_W-3:0], h_i[rsi_pkg::H_W-1 -: 2]};
  assign trial = rsi_pkg::REM_W'({root_i, 2'b01});
  assign take  = remsh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= side_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    hit    <= side_i.hit;
    tca    <= side_i.tca;
    rem_o  <= take ? remsh - trial : remsh;
    root_o <= {root_i[rsi_pkg::RT_W-2:0], take};
    h_o    <= h_i << 2;
  end

  assign side_o = {vld, hit, tca};

endmodule

FILE: sv/ray_sphere_intersect_unit.sv
`timescale 1ns / 1ps
// Ray/sphere intersection, fully pipelined: one beat may start every cycle and
// busy stays low. Each result appears on res for one cycle with done high,
// after its ray passes through six front stages
// (difference, products, dot sums, split tca products, tca square, discriminant),
// forty square-root stages that each settle one root bit, and the output
// register. The receiver cannot stall, so results must be taken as they come.
`include "ray_sphere_intersect_unit_macros.svh"
module ray_sphere_intersect_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rsi_pkg::in_t   ray,
  output logic           done,
  output rsi_pkg::out_t  res
);

  rsi_pkg::side_t            side [rsi_pkg::RT_W+1];
  logic [rsi_pkg::REM_W-1:0] rem  [rsi_pkg::RT_W+1];
  logic [rsi_pkg::RT_W-1:0]  root [rsi_pkg::RT_W+1];
  logic [rsi_pkg::H_W-1:0]   hv   [rsi_pkg::RT_W+1];

  logic signed [rsi_pkg::NF_W-1:0] near_w, far_w;
  logic signed [rsi_pkg::OUT_W-1:0] near_s, far_s;

  localparam logic signed [rsi_pkg::NF_W-1:0] SMAX =
    rsi_pkg::NF_W'({1'b0, {(rsi_pkg::OUT_W-1){1'b1}}});
  localparam logic signed [rsi_pkg::NF_W-1:0] SMIN = -SMAX - 1;

  assign busy = 1'b0;

  rsi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_vld (start & ~busy),
    .item   (ray),
    .side   (side[0]),
    .h      (hv[0])
  );

  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar g = 0; g < rsi_pkg::RT_W; g++) begin : g_sqrt
    rsi_sqrt_stage u_stage (
      .clk    (clk),
      .rst    (rst),
      .side_i (side[g]),
      .rem_i  (rem[g]),
      .root_i (root[g]),
      .h_i    (hv[g]),
      .side_o (side[g+1]),
      .rem_o  (rem[g+1]),
      .root_o (root[g+1]),
      .h_o    (hv[g+1])
    );
  end

  assign near_w = $signed(rsi_pkg::NF_W'(side[rsi_pkg::RT_W].tca))
                - $signed(rsi_pkg::NF_W'(root[rsi_pkg::RT_W]));
  assign far_w  = $signed(rsi_pkg::NF_W'(side[rsi_pkg::RT_W].tca))
                + $signed(rsi_pkg::NF_W'(root[rsi_pkg::RT_W]));

  always_comb begin
    if (near_w > SMAX) begin
      near_s = SMAX[rsi_pkg::OUT_W-1:0];
    end else if (near_w < SMIN) begin
      near_s = SMIN[rsi_pkg::OUT_W-1:0];
    end else begin
      near_s = near_w[rsi_pkg::OUT_W-1:0];
    end
    if (far_w > SMAX) begin
      far_s = SMAX[rsi_pkg::OUT_W-1:0];
    end else begin
      far_s = far_w[rsi_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[rsi_pkg::RT_W].vld;
    end
  end

  always_ff @(posedge clk) begin
    res.hit    <= side[rsi_pkg::RT_W].hit;
    res.near_t <= side[rsi_pkg::RT_W].hit ? near_s : '0;
    res.far_t  <= side[rsi_pkg::RT_W].hit ? far_s : '0;
  end

  `RSI_ASSERT_IMP(a_latency, start, ##(rsi_pkg::LATENCY) done)
  `RSI_ASSERT_IMP(a_no_phantom, !start, ##(rsi_pkg::LATENCY) !done)
  `RSI_ASSERT_IMP(a_miss_zero, done && !res.hit, (res.near_t == '0 && res.far_t == '0))
  `RSI_ASSERT_IMP(a_order, done && res.hit, res.near_t <= res.far_t)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  class hit_scoreboard;
    rsi_pkg::out_t pending_hits[$];
    int errors;
    int checked;
    int hits_seen;

    function logic [127:0] isqrt128(logic [127:0] v);
      logic [127:0] acc;
      logic [127:0] cand;
      acc = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = acc | (128'd1 << b);
        if (cand * cand <= v) acc = cand;
      end
      return acc;
    endfunction

    function logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_ray(rsi_pkg::in_t r);
      logic signed [127:0] lv [3];
      logic signed [127:0] dv [3];
      logic signed [127:0] dotp, lenl, tca, hh, thc;
      rsi_pkg::out_t e;
      lv[0] = 128'(r.center_x) - 128'(r.origin_x);
      lv[1] = 128'(r.center_y) - 128'(r.origin_y);
      lv[2] = 128'(r.center_z) - 128'(r.origin_z);
      dv[0] = 128'(r.dir_x);
      dv[1] = 128'(r.dir_y);
      dv[2] = 128'(r.dir_z);
      dotp = 0;
      lenl = 0;
      for (int i = 0; i < 3; i++) begin
        dotp += lv[i] * dv[i];
        lenl += lv[i] * lv[i];
      end
      e = '0;
      if (dotp >= 0) begin
        tca = dotp >>> rsi_pkg::FRAC_W;
        hh = 128'($unsigned(r.sphere_radius)) * 128'($unsigned(r.sphere_radius))
             + tca * tca - lenl;
        if (hh >= 0) begin
          thc = isqrt128(hh);
          e.hit = 1'b1;
          e.near_t = clamp32(tca - thc);
          e.far_t = clamp32(tca + thc);
        end
      end
      pending_hits.insert(pending_hits.size(), e);
    endfunction

    function void check_result(rsi_pkg::out_t got);
      rsi_pkg::out_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b near=%0d far=%0d",
                 $time, got.hit, got.near_t, got.far_t);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      checked++;
      if (got.hit) hits_seen++;
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, got.hit);
        errors++;
      end
      if (got.near_t !== e.near_t) begin
        $display("%0t: near_t expected %0d actual %0d", $time, e.near_t, got.near_t);
        errors++;
      end
      if (got.far_t !== e.far_t) begin
        $display("%0t: far_t expected %0d actual %0d", $time, e.far_t, got.far_t);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  rsi_pkg::in_t ray;
  logic done;
  rsi_pkg::out_t res;

  hit_scoreboard sb;
  int idle_pct;
  int beats_in;
  int quiet_cycles;

  ray_sphere_intersect_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ray(ray), .done(done), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_ray(ray);
        beats_in++;
      end
      if (done) sb.check_result(res);
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic signed [rsi_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $signed(rsi_pkg::COORD_W'($urandom));
      1: return $signed(rsi_pkg::COORD_W'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000));
      default: return $signed(rsi_pkg::COORD_W'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16));
    endcase
  endfunction

  function automatic rsi_pkg::in_t rand_ray();
    rsi_pkg::in_t r;
    int mode;
    mode = $urandom_range(0, 9);
    r.origin_x = rand_coord();
    r.origin_y = rand_coord();
    r.origin_z = rand_coord();
    r.center_x = rand_coord();
    r.center_y = rand_coord();
    r.center_z = rand_coord();
    if (mode < 6) begin
      // small random direction with non-negative x, center placed ahead of the origin along x
      r.dir_x = $signed(rsi_pkg::COORD_W'($urandom_range(0, 8192) - 4096));
      r.dir_y = $signed(rsi_pkg::COORD_W'($urandom_range(0, 8192) - 4096));
      r.dir_z = $signed(rsi_pkg::COORD_W'($urandom_range(0, 8192) - 4096));
      r.center_x = r.origin_x + $signed(rsi_pkg::COORD_W'($urandom_range(0, 65535)));
      r.sphere_radius = rsi_pkg::RAD_W'($urandom_range(0, 2 ** 18));
      if (r.dir_x < 0) r.dir_x = -r.dir_x;
    end else begin
      r.dir_x = rand_coord();
      r.dir_y = rand_coord();
      r.dir_z = rand_coord();
      r.sphere_radius = rsi_pkg::RAD_W'($urandom);
    end
    return r;
  endfunction

  task automatic send_ray(rsi_pkg::in_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    ray <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (rsi_pkg::LATENCY + 5) @(negedge clk);
  endtask

  function automatic rsi_pkg::in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int cx, int cy, int cz, int rad);
    rsi_pkg::in_t r;
    r.origin_x = rsi_pkg::COORD_W'(ox);
    r.origin_y = rsi_pkg::COORD_W'(oy);
    r.origin_z = rsi_pkg::COORD_W'(oz);
    r.dir_x = rsi_pkg::COORD_W'(dx);
    r.dir_y = rsi_pkg::COORD_W'(dy);
    r.dir_z = rsi_pkg::COORD_W'(dz);
    r.center_x = rsi_pkg::COORD_W'(cx);
    r.center_y = rsi_pkg::COORD_W'(cy);
    r.center_z = rsi_pkg::COORD_W'(cz);
    r.sphere_radius = rsi_pkg::RAD_W'(rad);
    return r;
  endfunction

  initial begin
    rsi_pkg::in_t r;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    ray = '0;
    idle_pct = 0;
    beats_in = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // hit, behind, tangent, miss, zero dir, non-unit dir, extremes
    send_ray(make_ray(0, 0, 0, 4096, 0, 0, 40960, 0, 0, 8192));
    send_ray(make_ray(0, 0, 0, -4096, 0, 0, 40960, 0, 0, 8192));
    send_ray(make_ray(0, 0, 0, 4096, 0, 0, 40960, 8192, 0, 8192));
    send_ray(make_ray(0, 0, 0, 4096, 0, 0, 40960, 8193, 0, 8192));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 100, 0, 0, 8192));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 100000, 0, 0, 8192));
    send_ray(make_ray(0, 0, 0, 40960, 4096, 0, 40960, 0, 0, 4096));
    send_ray(make_ray(0, 0, 0, 0, 0, 4096, 0, 0, 0, 0));
    send_ray(make_ray(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                      8388607, 8388607, 8388607, 8388607));
    send_ray(make_ray(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                      -8388608, -8388608, -8388608, 8388607));
    send_ray(make_ray(-8388608, 0, 0, 8388607, 0, 0, 8388607, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, -8388608, -8388608, -8388608, 0, 0, 0, 8388607));
    send_ray(make_ray(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                      -8388608, 8388607, -8388608, 0));
    send_ray('1);
    send_ray('0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 13 : ((ph == 1) ? 76 : 0);
      for (int n = 0; n < 630; n++) begin
        r = rand_ray();
        send_ray(r);
        if (n == 300 && ph == 1) drain();
      end
    end
    drain();

    $display("Ran %0d rays, %0d results checked, %0d hits, with and without sender gaps.",
             beats_in, sb.checked, sb.hits_seen);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
